// ----- src/rau_pkg.sv -----
`timescale 1ns / 1ps
package rau_pkg;
  localparam int WORD_BITS = 32;
  localparam int MAG_BITS = 2 * WORD_BITS + 1;

  typedef enum logic [1:0] {
    OP_ADD = 2'd0,
    OP_SUB = 2'd1,
    OP_MUL = 2'd2,
    OP_DIV = 2'd3
  } opcode_t;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_ZERO = 2'd1,
    ST_OVF  = 2'd2
  } status_t;

  typedef enum logic [8:0] {
    S_IDLE  = 9'b000000001,
    S_MUL1  = 9'b000000010,
    S_MUL2  = 9'b000000100,
    S_MUL3  = 9'b000001000,
    S_COMB  = 9'b000010000,
    S_GCD   = 9'b000100000,
    S_DIVN  = 9'b001000000,
    S_DIVD  = 9'b010000000,
    S_OUT   = 9'b100000000
  } state_t;
endpackage

// ----- src/rational_arithmetic_unit.sv -----
`timescale 1ns / 1ps
// channel  | valid     | ready     | payload
// request  | in_valid  | in_ready  | opcode a_num a_den b_num b_den
// result   | out_valid | out_ready | res_num res_den status
// one request at a time; in_ready is low while a request is in work
// steps: setup states MUL1, MUL2, MUL3 and COMB, a binary gcd, two 65-step restoring
// divisions and the OUT state; errors finish in IDLE, a zero result in COMB
// the divide steps and the gcd's gx - gy step share the 65-bit subtractor; gy - gx has its own
// rst clears state and out_valid; results hold until out_ready
module rational_arithmetic_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  opcode,
  input  logic signed [31:0] a_num,
  input  logic signed [31:0] a_den,
  input  logic signed [31:0] b_num,
  input  logic signed [31:0] b_den,
  output logic        out_valid,
  input  logic        out_ready,
  output logic signed [31:0] res_num,
  output logic [30:0] res_den,
  output logic [1:0]  status
);
  localparam int W = rau_pkg::WORD_BITS;
  localparam int M = rau_pkg::MAG_BITS;
  localparam int CW = $clog2(M + 1);

  rau_pkg::state_t state;
  logic [1:0] op;
  logic [W-1:0] na, da, nb, db;
  logic sa, sb, neg;
  logic [M-1:0] p, q, den, mag;
  logic [M-1:0] gx, gy, quo, rem;
  logic [CW-1:0] shf, cnt;
  logic [M-1:0] mul_r;
  logic [W-1:0] ma, mb;
  logic [M:0] diff;
  logic [M-1:0] sub_a, sub_b;
  logic [M:0] rem_sh;

  function automatic logic [W-1:0] mag_of(input logic [31:0] v);
    logic [W-1:0] t;
    t = v[W-1:0];
    return t[W-1] ? (~t + 1'b1) : t;
  endfunction

  assign in_ready = (state == rau_pkg::S_IDLE) && !out_valid;

  always_comb begin
    ma = na;
    mb = db;
    unique case (state)
      rau_pkg::S_MUL1: begin
        ma = na;
        mb = (op == rau_pkg::OP_MUL) ? nb : db;
      end
      rau_pkg::S_MUL2: begin
        ma = nb;
        mb = da;
      end
      default: begin
        ma = da;
        mb = db;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    mul_r <= M'(ma * mb);
  end

  always_comb begin
    rem_sh = {rem, quo[M-1]};
    sub_a = gx;
    sub_b = gy;
    if (state == rau_pkg::S_DIVN || state == rau_pkg::S_DIVD) begin
      sub_a = rem_sh[M-1:0];
      sub_b = gy;
    end
    diff = {1'b0, sub_a} - {1'b0, sub_b};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= rau_pkg::S_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready) out_valid <= 1'b0;
      unique case (state)
        rau_pkg::S_IDLE: begin
          if (in_valid && in_ready) begin
            op <= opcode;
            na <= mag_of(a_num);
            da <= mag_of(a_den);
            nb <= mag_of(b_num);
            db <= mag_of(b_den);
            sa <= a_num[W-1] ^ a_den[W-1];
            sb <= b_num[W-1] ^ b_den[W-1];
            if (a_den[W-1:0] == '0 || b_den[W-1:0] == '0 ||
                (opcode == rau_pkg::OP_DIV && b_num[W-1:0] == '0)) begin
              res_num <= '0;
              res_den <= '0;
              status <= rau_pkg::ST_ZERO;
              out_valid <= 1'b1;
            end else begin
              state <= rau_pkg::S_MUL1;
            end
          end
        end
        rau_pkg::S_MUL1: state <= rau_pkg::S_MUL2;
        rau_pkg::S_MUL2: begin
          p <= mul_r;
          state <= rau_pkg::S_MUL3;
        end
        rau_pkg::S_MUL3: begin
          q <= mul_r;
          state <= rau_pkg::S_COMB;
        end
        rau_pkg::S_COMB: begin
          logic sq;
          logic [M-1:0] m, d;
          sq = (op == rau_pkg::OP_SUB) ? !sb : sb;
          d = mul_r;
          if (op == rau_pkg::OP_MUL) begin
            m = p;
            neg <= sa ^ sb;
          end else if (op == rau_pkg::OP_DIV) begin
            m = p;
            d = q;
            neg <= sa ^ sb;
          end else if (sa == sq) begin
            m = p + q;
            neg <= sa;
          end else if (p >= q) begin
            m = p - q;
            neg <= sa;
          end else begin
            m = q - p;
            neg <= sq;
          end
          mag <= m;
          den <= d;
          gx <= m;
          gy <= d;
          shf <= '0;
          if (m == '0) begin
            res_num <= '0;
            res_den <= 31'd1;
            status <= rau_pkg::ST_OK;
            out_valid <= 1'b1;
            state <= rau_pkg::S_IDLE;
          end else begin
            state <= rau_pkg::S_GCD;
          end
        end
        rau_pkg::S_GCD: begin
          // binary gcd, gx and gy both nonzero
          if (!gx[0] && !gy[0]) begin
            gx <= gx >> 1;
            gy <= gy >> 1;
            shf <= shf + 1'b1;
          end else if (!gx[0]) begin
            gx <= gx >> 1;
          end else if (!gy[0]) begin
            gy <= gy >> 1;
          end else if (gx == gy) begin
            gy <= gx << shf;
            quo <= mag;
            rem <= '0;
            cnt <= '0;
            state <= rau_pkg::S_DIVN;
          end else if (!diff[M]) begin
            gx <= diff[M-1:0];
          end else begin
            gy <= gy - gx;
          end
        end
        rau_pkg::S_DIVN, rau_pkg::S_DIVD: begin
          if (cnt == CW'(M - 1)) begin
            cnt <= '0;
            rem <= '0;
            if (state == rau_pkg::S_DIVN) begin
              mag <= {quo[M-2:0], !diff[M]};
              quo <= den;
              state <= rau_pkg::S_DIVD;
            end else begin
              den <= {quo[M-2:0], !diff[M]};
              state <= rau_pkg::S_OUT;
            end
          end else begin
            if (!diff[M]) begin
              rem <= diff[M-1:0];
              quo <= {quo[M-2:0], 1'b1};
            end else begin
              rem <= rem_sh[M-1:0];
              quo <= {quo[M-2:0], 1'b0};
            end
            cnt <= cnt + 1'b1;
          end
        end
        rau_pkg::S_OUT: begin
          logic [M-1:0] lim;
          lim = M'((64'd1 << (W - 1)) - 64'd1);
          if (den > lim || mag > (neg ? lim + 1'b1 : lim)) begin
            res_num <= '0;
            res_den <= '0;
            status <= rau_pkg::ST_OVF;
          end else begin
            res_num <= 32'(neg ? (~mag + 1'b1) : mag);
            res_den <= den[30:0];
            status <= rau_pkg::ST_OK;
          end
          out_valid <= 1'b1;
          state <= rau_pkg::S_IDLE;
        end
        default: state <= rau_pkg::S_IDLE;
      endcase
    end
  end
endmodule

// ----- src/rau_checker.sv -----
`timescale 1ns / 1ps
module rau_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] res_num,
  input logic [30:0] res_den,
  input logic [1:0]  status
);
  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !in_ready) else $error("request taken while result pending");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(res_num) && $stable(status))
    else $error("result changed while stalled");
  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && status != rau_pkg::ST_OK |-> res_num == '0 && res_den == '0)
    else $error("error result not zero");
  a_ok_den: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == rau_pkg::ST_OK |-> res_den != '0)
    else $error("zero denominator on ok result");
endmodule

bind rational_arithmetic_unit rau_checker u_rau_checker (
  .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready),
  .out_valid(out_valid), .out_ready(out_ready), .res_num(res_num),
  .res_den(res_den), .status(status)
);

// ----- bench/tb.sv -----
`timescale 1ns / 1ps
module tb;
  typedef struct packed {
    logic [31:0] num;
    logic [30:0] den;
    logic [1:0]  st;
  } fraction_t;

  localparam int WATCHDOG_LIMIT = 5000;
  localparam int DRAIN_CYCLES   = 300;
  localparam int RANDOM_ITEMS   = 1520;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [1:0]  opcode = rau_pkg::OP_ADD;
  logic signed [31:0] a_num = '0;
  logic signed [31:0] a_den = '0;
  logic signed [31:0] b_num = '0;
  logic signed [31:0] b_den = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic signed [31:0] res_num;
  logic [30:0] res_den;
  logic [1:0]  status;

  fraction_t   expected_q[$];
  int          errors = 0;
  int          idle_cycles = 0;
  int          ready_hold = 0;
  bit          no_stall = 1'b0;

  rational_arithmetic_unit i_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .opcode(opcode), .a_num(a_num), .a_den(a_den), .b_num(b_num), .b_den(b_den),
    .out_valid(out_valid), .out_ready(out_ready),
    .res_num(res_num), .res_den(res_den), .status(status)
  );

  always #5 clk = ~clk;

  function automatic logic [63:0] magnitude(logic [31:0] x);
    logic [31:0] m;
    m = x[31] ? (~x + 32'd1) : x;
    return {32'd0, m};
  endfunction

  function automatic fraction_t rational_result(logic [1:0] op, logic [31:0] an,
                                                logic [31:0] ad, logic [31:0] bn,
                                                logic [31:0] bd);
    logic [63:0] na, da, nb, db, p, q, mag, den, x, y, r, lim;
    logic        sa, sb, sq, neg;
    fraction_t   f;
    na = magnitude(an);
    da = magnitude(ad);
    nb = magnitude(bn);
    db = magnitude(bd);
    sa = an[31] ^ ad[31];
    sb = bn[31] ^ bd[31];
    f = '{num: '0, den: '0, st: rau_pkg::ST_ZERO};
    if (da == 0 || db == 0 || (op == rau_pkg::OP_DIV && nb == 0)) return f;
    if (op == rau_pkg::OP_ADD || op == rau_pkg::OP_SUB) begin
      p = na * db;
      q = nb * da;
      sq = (op == rau_pkg::OP_SUB) ? ~sb : sb;
      if (sa == sq) begin
        mag = p + q;
        neg = sa;
      end else if (p >= q) begin
        mag = p - q;
        neg = sa;
      end else begin
        mag = q - p;
        neg = sq;
      end
      den = da * db;
    end else if (op == rau_pkg::OP_MUL) begin
      mag = na * nb;
      den = da * db;
      neg = sa ^ sb;
    end else begin
      mag = na * db;
      den = da * nb;
      neg = sa ^ sb;
    end
    if (mag == 0) return '{num: '0, den: 31'd1, st: rau_pkg::ST_OK};
    x = mag;
    y = den;
    while (y != 0) begin
      r = x % y;
      x = y;
      y = r;
    end
    mag = mag / x;
    den = den / x;
    lim = 64'h7fff_ffff;
    if (den > lim || mag > (neg ? lim + 1 : lim)) begin
      return '{num: '0, den: '0, st: rau_pkg::ST_OVF};
    end
    f.num = neg ? (32'd0 - mag[31:0]) : mag[31:0];
    f.den = den[30:0];
    f.st = rau_pkg::ST_OK;
    return f;
  endfunction

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(0, 3);
    if (r < 95) return $urandom_range(4, 20);
    return $urandom_range(50, 300);
  endfunction

  function automatic logic [31:0] pick_operand(bit is_den);
    int r;
    r = $urandom_range(0, 99);
    if (is_den && r < 3) return 32'd0;
    if (r < 45) return $urandom_range(0, 40) - 20;
    if (r < 70) return $urandom_range(0, 4000) - 2000;
    if (r < 80) begin
      case ($urandom_range(0, 4))
        0: return 32'h8000_0000;
        1: return 32'h7fff_ffff;
        2: return 32'hffff_ffff;
        3: return 32'd1;
        default: return 32'h0001_0000;
      endcase
    end
    if (r < 90) return $urandom_range(0, 32'h1_ffff) - 32'h1_0000;
    return $urandom;
  endfunction

  task automatic send_request(logic [1:0] op, logic [31:0] an, logic [31:0] ad,
                              logic [31:0] bn, logic [31:0] bd, int gap);
    in_valid <= 1'b1;
    opcode <= op;
    a_num <= an;
    a_den <= ad;
    b_num <= bn;
    b_den <= bd;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    expected_q.push_back(rational_result(op, an, ad, bn, bd));
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic test_basic_ops();
    send_request(rau_pkg::OP_ADD, 32'd1, 32'd2, 32'd1, 32'd3, 0);
    send_request(rau_pkg::OP_SUB, 32'd1, 32'd2, 32'd1, 32'd3, 1);
    send_request(rau_pkg::OP_MUL, -32'sd3, 32'd4, 32'd2, -32'sd9, 0);
    send_request(rau_pkg::OP_DIV, 32'd5, -32'sd6, -32'sd10, 32'd3, 2);
    send_request(rau_pkg::OP_SUB, 32'd7, 32'd3, 32'd7, 32'd3, 0);
  endtask

  task automatic test_errors();
    send_request(rau_pkg::OP_ADD, 32'd1, 32'd0, 32'd1, 32'd1, 0);
    send_request(rau_pkg::OP_MUL, 32'd1, 32'd1, 32'd1, 32'd0, 3);
    send_request(rau_pkg::OP_DIV, 32'd4, 32'd5, 32'd0, 32'd7, 0);
    send_request(rau_pkg::OP_DIV, 32'd0, 32'd5, 32'd0, 32'd0, 0);
    send_request(rau_pkg::OP_MUL, 32'd0, -32'sd5, 32'd9, 32'd2, 1);
  endtask

  task automatic test_extremes();
    send_request(rau_pkg::OP_ADD, 32'h7fff_ffff, 32'd1, 32'h7fff_ffff, 32'd1, 0);
    send_request(rau_pkg::OP_MUL, 32'h8000_0000, 32'd1, 32'd1, 32'd1, 0);
    send_request(rau_pkg::OP_MUL, 32'h8000_0000, 32'd1, -32'sd1, 32'd1, 0);
    send_request(rau_pkg::OP_MUL, 32'd1, 32'h0001_0000, 32'd1, 32'h0001_0000, 0);
    send_request(rau_pkg::OP_MUL, 32'd1, 32'h8000_0000, 32'd2, 32'd1, 0);
    send_request(rau_pkg::OP_DIV, 32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff,
                 32'h7fff_ffff, 0);
    send_request(rau_pkg::OP_SUB, 32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff,
                 32'h8000_0000, 0);
    send_request(rau_pkg::OP_ADD, 32'hffff_ffff, 32'hffff_ffff, 32'h8000_0000,
                 32'h8000_0000, 0);
    send_request(rau_pkg::OP_DIV, 32'd1, 32'h7fff_ffff, 32'h7fff_ffff, 32'd1, 0);
    send_request(rau_pkg::OP_ADD, 32'h8000_0000, 32'd1, -32'sd1, 32'd1, 5);
  endtask

  task automatic test_random(int count);
    for (int i = 0; i < count; i++) begin
      no_stall = (i / 200) % 4 == 3;
      send_request(2'($urandom_range(0, 3)), pick_operand(1'b0), pick_operand(1'b1),
                   pick_operand(1'b0), pick_operand(1'b1), no_stall ? 0 : gap_len());
    end
    no_stall = 1'b0;
  endtask

  always @(posedge clk) begin
    if (rst || no_stall) begin
      out_ready <= !rst;
      ready_hold <= 0;
    end else if (ready_hold != 0) begin
      out_ready <= 1'b0;
      ready_hold <= ready_hold - 1;
    end else if ($urandom_range(0, 9) == 0) begin
      out_ready <= 1'b0;
      ready_hold <= gap_len();
    end else begin
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    fraction_t e;
    if (!rst && out_valid && out_ready) begin
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected result %0d/%0d status %0d", $time, res_num, res_den,
                 status);
        errors++;
      end else begin
        e = expected_q.pop_front();
        if (res_num !== e.num) begin
          $display("%0t: res_num expected %0d actual %0d", $time, $signed(e.num), res_num);
          errors++;
        end
        if (res_den !== e.den) begin
          $display("%0t: res_den expected %0d actual %0d", $time, e.den, res_den);
          errors++;
        end
        if (status !== e.st) begin
          $display("%0t: status expected %0d actual %0d", $time, e.st, status);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("tb: done, errors");
        $finish;
      end
    end
  end

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_basic_ops();
    test_errors();
    test_extremes();
    test_random(RANDOM_ITEMS);
    in_valid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0 && expected_q.size() == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end
endmodule
